// ===== rtl/core/cbez_pkg.sv =====
// Shared types and constants for the cubic Bezier point evaluator.
// Used by cbez_cfg, cbez_axis and cubic_bezier_point_eval; depends on nothing.
package cbez_pkg;

    // Fixed field widths
    localparam int T_FRAC   = 16;                 // fraction bits of t
    localparam int T_W      = T_FRAC + 1;         // t and u, 1.0 included
    localparam int COORD_W  = 16;                 // control point / result coordinate
    localparam int LERP_W   = T_FRAC + COORD_W;   // first De Casteljau level
    localparam int BLEND_W  = 2 * T_FRAC + COORD_W; // second level
    localparam int SPLIT_W  = 24;                 // low slice of the second level
    localparam int HIGH_W   = BLEND_W - SPLIT_W;  // high slice of the second level
    localparam int PLO_W    = T_W + SPLIT_W;      // unsigned partial product
    localparam int PHI_W    = T_W + 1 + HIGH_W;   // signed partial product
    localparam int SHIFT    = 3 * T_FRAC;         // scale of the final sum
    localparam int ACC_W    = SHIFT + COORD_W + 4;

    // Register stages from the input register to the output register
    localparam int NUM_STG  = 5;

    localparam logic [T_W-1:0]          T_ONE    = T_W'(1) << T_FRAC;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (SHIFT - 1);

    // Configuration register map
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Per-stage load enables of the datapath
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_ctl;

endpackage

// ===== rtl/core/cbez_cfg.sv =====
// Control point register file of the cubic Bezier point evaluator.
// Depends on cbez_pkg.
module cbez_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbez_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbez_pkg::COORD_W-1:0]        i_cfg_data,
    output cbez_pkg::t_coord                    o_px [4],
    output cbez_pkg::t_coord                    o_py [4]
);

    cbez_pkg::t_coord r_regs [cbez_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbez_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < cbez_pkg::CFG_IDX_W'(cbez_pkg::NUM_REGS))) begin
            r_regs[i_cfg_idx[cbez_pkg::REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    assign o_px[0] = r_regs[cbez_pkg::REG_P0_X];
    assign o_py[0] = r_regs[cbez_pkg::REG_P0_Y];
    assign o_px[1] = r_regs[cbez_pkg::REG_P1_X];
    assign o_py[1] = r_regs[cbez_pkg::REG_P1_Y];
    assign o_px[2] = r_regs[cbez_pkg::REG_P2_X];
    assign o_py[2] = r_regs[cbez_pkg::REG_P2_Y];
    assign o_px[3] = r_regs[cbez_pkg::REG_P3_X];
    assign o_py[3] = r_regs[cbez_pkg::REG_P3_Y];

endmodule

// ===== rtl/core/cbez_axis.sv =====
// Four-stage De Casteljau datapath for one coordinate axis.
// Depends on cbez_pkg; load enables and staged t/u come from the top level.
module cbez_axis (
    input  logic                            i_clk,
    input  cbez_pkg::t_ctl                  i_ctl,
    input  logic [cbez_pkg::T_W-1:0]        i_u0,
    input  logic [cbez_pkg::T_W-1:0]        i_t0,
    input  logic [cbez_pkg::T_W-1:0]        i_u1,
    input  logic [cbez_pkg::T_W-1:0]        i_t1,
    input  logic [cbez_pkg::T_W-1:0]        i_u2,
    input  logic [cbez_pkg::T_W-1:0]        i_t2,
    input  cbez_pkg::t_coord                i_pt [4],
    output cbez_pkg::t_coord                o_coord
);

    // first level: three lerps of the control points
    logic signed [cbez_pkg::T_W:0]              w_us0, w_ts0;
    logic signed [cbez_pkg::T_W+cbez_pkg::COORD_W:0] w_pa_u [3];
    logic signed [cbez_pkg::T_W+cbez_pkg::COORD_W:0] w_pa_t [3];
    logic signed [cbez_pkg::T_W+cbez_pkg::COORD_W+1:0] w_sa [3];
    logic signed [cbez_pkg::LERP_W-1:0]         r_a [3];

    // second level: two lerps of the first level
    logic signed [cbez_pkg::T_W:0]              w_us1, w_ts1;
    logic signed [cbez_pkg::T_W+cbez_pkg::LERP_W:0] w_pb_u [2];
    logic signed [cbez_pkg::T_W+cbez_pkg::LERP_W:0] w_pb_t [2];
    logic signed [cbez_pkg::T_W+cbez_pkg::LERP_W+1:0] w_sb [2];
    logic signed [cbez_pkg::BLEND_W-1:0]        r_b [2];

    // third level, split into partial products
    logic signed [cbez_pkg::T_W:0]              w_us2, w_ts2;
    logic [cbez_pkg::PLO_W-1:0]                 r_plu, r_plt;
    logic signed [cbez_pkg::PHI_W-1:0]          r_phu, r_pht;

    logic signed [cbez_pkg::ACC_W-1:0]          w_acc;
    cbez_pkg::t_coord                           r_coord;

    always_comb begin
        w_us0 = $signed({1'b0, i_u0});
        w_ts0 = $signed({1'b0, i_t0});
        for (int i = 0; i < 3; i++) begin
            w_pa_u[i] = w_us0 * i_pt[i];
            w_pa_t[i] = w_ts0 * i_pt[i+1];
            w_sa[i]   = (cbez_pkg::T_W + cbez_pkg::COORD_W + 2)'(w_pa_u[i])
                      + (cbez_pkg::T_W + cbez_pkg::COORD_W + 2)'(w_pa_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= $signed(w_sa[i][cbez_pkg::LERP_W-1:0]);
            end
        end
    end

    always_comb begin
        w_us1 = $signed({1'b0, i_u1});
        w_ts1 = $signed({1'b0, i_t1});
        for (int i = 0; i < 2; i++) begin
            w_pb_u[i] = w_us1 * r_a[i];
            w_pb_t[i] = w_ts1 * r_a[i+1];
            w_sb[i]   = (cbez_pkg::T_W + cbez_pkg::LERP_W + 2)'(w_pb_u[i])
                      + (cbez_pkg::T_W + cbez_pkg::LERP_W + 2)'(w_pb_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            for (int i = 0; i < 2; i++) begin
                r_b[i] <= $signed(w_sb[i][cbez_pkg::BLEND_W-1:0]);
            end
        end
    end

    assign w_us2 = $signed({1'b0, i_u2});
    assign w_ts2 = $signed({1'b0, i_t2});

    // Hold the low slice unsigned and the high slice signed
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_plu <= i_u2 * r_b[0][cbez_pkg::SPLIT_W-1:0];
            r_plt <= i_t2 * r_b[1][cbez_pkg::SPLIT_W-1:0];
            r_phu <= w_us2 * $signed(r_b[0][cbez_pkg::BLEND_W-1:cbez_pkg::SPLIT_W]);
            r_pht <= w_ts2 * $signed(r_b[1][cbez_pkg::BLEND_W-1:cbez_pkg::SPLIT_W]);
        end
    end

    // Recombine the slices, add one half and keep the integer part
    assign w_acc = ((cbez_pkg::ACC_W'(r_phu) + cbez_pkg::ACC_W'(r_pht)) <<< cbez_pkg::SPLIT_W)
                 + $signed({{(cbez_pkg::ACC_W - cbez_pkg::PLO_W){1'b0}}, r_plu})
                 + $signed({{(cbez_pkg::ACC_W - cbez_pkg::PLO_W){1'b0}}, r_plt})
                 + cbez_pkg::RND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_coord <= $signed(w_acc[cbez_pkg::SHIFT +: cbez_pkg::COORD_W]);
        end
    end

    assign o_coord = r_coord;

endmodule

// ===== rtl/core/cubic_bezier_point_eval.sv =====
// Top level of the cubic Bezier point evaluator: input stage, valid/stall
// pipeline control, control point registers and one datapath per axis.
// Depends on cbez_pkg, cbez_cfg and cbez_axis.
//
// Usage
//   Write the four control points through the plain write port (index 0..7:
//   p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y; higher indexes are
//   dropped) while no request is in flight. Then send one curve parameter t
//   (Q1.16, 0x10000 = 1.0, larger values clamp to 1.0) per request on the
//   input channel; each request yields one point (x, y) on the output channel,
//   rounded to nearest with ties toward plus infinity.
//   Path: a request passes through the input register, two lerp levels,
//   partial products and final sum before its point is valid.
//   Throughput: one request per cycle while the receiver does not stall; every
//   stage has its own valid bit and loads whenever it is empty or the stage
//   after it moves, so bubbles fill. Stall: when the receiver stalls, the
//   output register holds its point and the stall propagates back stage by
//   stage; o_stall rises only when every stage holds a request, and nothing is lost or repeated.
//   Reset (synchronous, active low): empties the pipeline and clears all
//   control points to zero.
module cubic_bezier_point_eval (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cbez_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbez_pkg::COORD_W-1:0]    i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cbez_pkg::T_W-1:0]        i_t_param,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [cbez_pkg::COORD_W-1:0] o_curve_x,
    output logic signed [cbez_pkg::COORD_W-1:0] o_curve_y
);

    logic [cbez_pkg::NUM_STG-1:0]   r_v;
    logic [cbez_pkg::NUM_STG-1:0]   w_rdy;
    logic [cbez_pkg::T_W-1:0]       n_t0, n_u0;
    logic [cbez_pkg::T_W-1:0]       r_t0, r_u0, r_t1, r_u1, r_t2, r_u2;
    cbez_pkg::t_ctl                 w_ctl;
    cbez_pkg::t_coord               w_px [4];
    cbez_pkg::t_coord               w_py [4];

    // A stage may load when it is empty or its successor moves on
    always_comb begin
        w_rdy[cbez_pkg::NUM_STG-1] = !r_v[cbez_pkg::NUM_STG-1] || !i_stall;
        for (int k = cbez_pkg::NUM_STG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < cbez_pkg::NUM_STG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Clamp t to 1.0 and form u = 1 - t
    always_comb begin
        n_t0 = (i_t_param > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE : i_t_param;
        n_u0 = cbez_pkg::T_ONE - n_t0;
    end

    // Carry t and u alongside the lerp stages that need them
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_t0 <= n_t0;
            r_u0 <= n_u0;
        end
        if (w_rdy[1]) begin
            r_t1 <= r_t0;
            r_u1 <= r_u0;
        end
        if (w_rdy[2]) begin
            r_t2 <= r_t1;
            r_u2 <= r_u1;
        end
    end

    assign w_ctl.ld1 = w_rdy[1];
    assign w_ctl.ld2 = w_rdy[2];
    assign w_ctl.ld3 = w_rdy[3];
    assign w_ctl.ld4 = w_rdy[4];

    cbez_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_px       (w_px),
        .o_py       (w_py)
    );

    cbez_axis u_axis_x (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_u0    (r_u0),
        .i_t0    (r_t0),
        .i_u1    (r_u1),
        .i_t1    (r_t1),
        .i_u2    (r_u2),
        .i_t2    (r_t2),
        .i_pt    (w_px),
        .o_coord (o_curve_x)
    );

    cbez_axis u_axis_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_u0    (r_u0),
        .i_t0    (r_t0),
        .i_u1    (r_u1),
        .i_t1    (r_t1),
        .i_u2    (r_u2),
        .i_t2    (r_t2),
        .i_pt    (w_py),
        .o_coord (o_curve_y)
    );

    assign o_valid = r_v[cbez_pkg::NUM_STG-1];
    assign o_stall = !w_rdy[0];

endmodule
